>>> hw/rtl/fsae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsae_pkg;

  localparam int TIME_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int REG_W   = 16;
  localparam int ALPHA_W = FRAC_W + 1;
  localparam int MUL_W   = FRAC_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CNT_W   = $clog2(FRAC_W);

  localparam logic [ALPHA_W-1:0] ONE          = ALPHA_W'(1) << FRAC_W;
  localparam logic [REG_W-1:0]   DUR_RESET    = REG_W'(200);
  localparam logic [REG_W-1:0]   DIST_RESET   = REG_W'(5120);
  localparam logic [CNT_W-1:0]   DIV_LAST_CNT = CNT_W'(FRAC_W - 1);

  // Command codes carried in tuser.
  localparam logic [1:0] FN_TICK     = 2'd0;
  localparam logic [1:0] FN_FADE_IN  = 2'd1;
  localparam logic [1:0] FN_FADE_OUT = 2'd2;

  // Register byte addresses.
  localparam logic [2:0] ADDR_DURATION = 3'd0;
  localparam logic [2:0] ADDR_DISTANCE = 3'd4;

  typedef enum logic [1:0] {
    PH_HIDDEN  = 2'd0,
    PH_IN      = 2'd1,
    PH_VISIBLE = 2'd2,
    PH_OUT     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MUL_SQ   = 2'd0,
    MUL_CUBE = 2'd1,
    MUL_OFF  = 2'd2
  } mul_sel_t;

  typedef enum logic [1:0] {
    RES_HIDDEN  = 2'd0,
    RES_VISIBLE = 2'd1,
    RES_ANIM    = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic      load_now;
    logic      load_stamp;
    logic      calc_elap;
    logic      div_init;
    logic      div_step;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      fade_in;
    logic      out_load;
    res_kind_t res_kind;
    phase_t    phase;
  } fsae_cmd_t;

  typedef struct packed {
    logic late;
    logic div_last;
    logic out_free;
  } fsae_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/fsae_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fsae_ctrl
  import fsae_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_func,
  output logic            in_ready,
  input  wire fsae_stat_t stat,
  output fsae_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAP,
    S_CHK,
    S_DIV,
    S_SQ,
    S_CUBE,
    S_OFF,
    S_OUTP
  } state_t;

  state_t    state, state_next;
  phase_t    mode, mode_next;
  res_kind_t res_kind, res_kind_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    res_kind_next = res_kind;
    cmd           = '0;
    cmd.mul_sel   = MUL_SQ;
    cmd.fade_in   = (mode == PH_IN);
    cmd.res_kind  = res_kind;
    cmd.phase     = mode;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_now = 1'b1;
          case (in_func)
            FN_FADE_IN: begin
              cmd.load_stamp = 1'b1;
              mode_next      = PH_IN;
            end
            FN_FADE_OUT: begin
              if (mode != PH_HIDDEN) begin
                cmd.load_stamp = 1'b1;
                mode_next      = PH_OUT;
              end
            end
            FN_TICK: begin
              unique case (mode)
                PH_HIDDEN: begin
                  res_kind_next = RES_HIDDEN;
                  state_next    = S_OUTP;
                end
                PH_VISIBLE: begin
                  res_kind_next = RES_VISIBLE;
                  state_next    = S_OUTP;
                end
                default: state_next = S_ELAP;
              endcase
            end
            default: ;
          endcase
        end
      end
      S_ELAP: begin
        cmd.calc_elap = 1'b1;
        state_next    = S_CHK;
      end
      S_CHK: begin
        if (stat.late) begin
          // The fade is over: settle in the end phase and report it.
          if (mode == PH_IN) begin
            mode_next     = PH_VISIBLE;
            res_kind_next = RES_VISIBLE;
          end else begin
            mode_next     = PH_HIDDEN;
            res_kind_next = RES_HIDDEN;
          end
          state_next = S_OUTP;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ;
        state_next  = S_CUBE;
      end
      S_CUBE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CUBE;
        state_next  = S_OFF;
      end
      S_OFF: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_OFF;
        res_kind_next = RES_ANIM;
        state_next    = S_OUTP;
      end
      S_OUTP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= PH_HIDDEN;
      res_kind <= RES_HIDDEN;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      res_kind <= res_kind_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fsae_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module fsae_dpath
  import fsae_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fsae_cmd_t         cmd,
  output fsae_stat_t             stat,
  input  wire logic [TIME_W-1:0] in_time,
  input  wire logic [REG_W-1:0]  duration,
  input  wire logic [REG_W-1:0]  slide_dist,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ALPHA_W-1:0]     out_alpha,
  output logic [REG_W-1:0]       out_offset,
  output logic                   out_active,
  output phase_t                 out_phase
);

  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  start_stamp;
  logic [TIME_W-1:0]  elapsed;
  logic [REG_W-1:0]   dur_eff;

  logic [REG_W-1:0]   rem;
  logic [FRAC_W-1:0]  quo;
  logic [CNT_W-1:0]   cnt;
  logic [REG_W:0]     rem_sh;
  logic [REG_W:0]     rem_diff;
  logic               rem_ge;

  logic [MUL_W-1:0]   x_next;
  logic [MUL_W-1:0]   x_q;
  logic [MUL_W-1:0]   cube_q;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;
  logic [MUL_W-1:0]   prod_hi;

  assign dur_eff = (duration == '0) ? DUR_RESET : duration;

  assign stat.late     = (elapsed >= TIME_W'(dur_eff));
  assign stat.div_last = (cnt == DIV_LAST_CNT);
  assign stat.out_free = !out_valid || out_ready;

  // Restoring division of (elapsed << FRAC_W) by the duration, one quotient
  // bit per cycle. The remainder always stays below the duration.
  assign rem_sh   = {rem, 1'b0};
  assign rem_ge   = (rem_sh >= {1'b0, dur_eff});
  assign rem_diff = rem_sh - {1'b0, dur_eff};

  assign x_next  = cmd.fade_in ? (ONE - {1'b0, quo}) : {1'b0, quo};
  assign prod_hi = prod[FRAC_W +: MUL_W];

  always_comb begin
    case (cmd.mul_sel)
      MUL_SQ: begin
        mul_a = x_next;
        mul_b = x_next;
      end
      MUL_CUBE: begin
        mul_a = prod_hi;
        mul_b = x_q;
      end
      default: begin
        mul_a = MUL_W'(slide_dist);
        mul_b = prod_hi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      now_q <= in_time;
    end
    if (cmd.calc_elap) begin
      elapsed <= (now_q >= start_stamp) ? (now_q - start_stamp) : '0;
    end
    if (cmd.div_init) begin
      rem <= elapsed[REG_W-1:0];
      quo <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff[REG_W-1:0] : rem_sh[REG_W-1:0];
      quo <= {quo[FRAC_W-2:0], rem_ge};
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
      if (cmd.mul_sel == MUL_SQ) begin
        x_q <= x_next;
      end
      if (cmd.mul_sel == MUL_OFF) begin
        cube_q <= prod_hi;
      end
    end
    if (cmd.out_load) begin
      case (cmd.res_kind)
        RES_HIDDEN: begin
          out_alpha  <= '0;
          out_offset <= slide_dist;
          out_active <= 1'b0;
          out_phase  <= PH_HIDDEN;
        end
        RES_VISIBLE: begin
          out_alpha  <= ONE;
          out_offset <= '0;
          out_active <= 1'b0;
          out_phase  <= PH_VISIBLE;
        end
        default: begin
          out_alpha  <= ONE - cube_q;
          out_offset <= prod[FRAC_W +: REG_W];
          out_active <= 1'b1;
          out_phase  <= cmd.phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_stamp <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load_stamp) begin
        start_stamp <= in_time;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fade_slide_animation_easer_top.sv
// A tick in a fade phase runs through the elapsed time, a restoring divider and
// three shared multiplies before its result; a tick while hidden or visible goes
// straight to the output, and one that ends a fade skips the divider.
// One item in work at a time: a start command leaves the block idle, while a tick
// holds off the next transfer until its result is loaded, which waits on any stall
// of an earlier result. Synchronous reset: hidden, start time 0, 200 ms, 20.0 px.
`timescale 1ns / 1ps
`default_nettype none

module fade_slide_animation_easer_top
  import fsae_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // now_time[31:0]
  input  wire logic [1:0]  s_tuser,   // func[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // alpha[16:0], offset[32:17], active[33],
                                      // phase[35:34], zero pad[39:36]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  fsae_cmd_t          cmd;
  fsae_stat_t         stat;
  logic [REG_W-1:0]   duration;
  logic [REG_W-1:0]   slide_dist;
  logic [ALPHA_W-1:0] alpha;
  logic [REG_W-1:0]   offset;
  logic               active;
  phase_t             phase;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration   <= DUR_RESET;
      slide_dist <= DIST_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_DISTANCE[2]) begin
        slide_dist <= pwdata[REG_W-1:0];
      end else begin
        duration <= pwdata[REG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_DISTANCE[2]) begin
      prdata = {16'b0, slide_dist};
    end else begin
      prdata = {16'b0, duration};
    end
  end

  fsae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsae_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_time    (s_tdata[TIME_W-1:0]),
    .duration   (duration),
    .slide_dist (slide_dist),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_alpha  (alpha),
    .out_offset (offset),
    .out_active (active),
    .out_phase  (phase)
  );

  assign m_tdata = {4'b0, phase, active, offset, alpha};

endmodule

`default_nettype wire

>>> hw/rtl/fsae_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fsae_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Only the fade phases report an animation in progress.
  a_active_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> m_tdata[34] == 1'b1)
    else $error("active flag outside a fade phase");

  // Hidden reports fully transparent and idle.
  a_hidden_vals: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[35:34] == 2'd0 |-> m_tdata[16:0] == 17'd0 && !m_tdata[33])
    else $error("bad hidden result");

  // Visible reports fully opaque with no offset.
  a_visible_vals: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[35:34] == 2'd2
      |-> m_tdata[16:0] == 17'h10000 && m_tdata[32:17] == 16'd0 && !m_tdata[33])
    else $error("bad visible result");

endmodule

bind fade_slide_animation_easer_top fsae_checker u_fsae_checker (.*);

`default_nettype wire

>>> sim/fade_slide_animation_easer_top_tb.sv
`timescale 1ns / 1ps

module fade_slide_animation_easer_top_tb;
  import fsae_pkg::*;

  localparam logic [1:0] FN_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_PER_SETTING = 292;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [REG_W-1:0]   offset;
    logic               active;
    phase_t             phase;
  } frame_t;

  // Tracks the fade engine state and queues the frames each tick must produce.
  class fade_scoreboard;
    logic [REG_W-1:0]  duration_reg = DUR_RESET;
    logic [REG_W-1:0]  distance_reg = DIST_RESET;
    phase_t            mode = PH_HIDDEN;
    logic [TIME_W-1:0] start_stamp = '0;
    frame_t            pending_frames[$];
    int                mismatches = 0;

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void set_register(logic [2:0] addr, logic [REG_W-1:0] value);
      if (addr == ADDR_DURATION) duration_reg = value;
      else if (addr == ADDR_DISTANCE) distance_reg = value;
    endfunction

    function int effective_duration();
      return (duration_reg == 0) ? 200 : int'(duration_reg);
    endfunction

    function logic [63:0] cube_q(logic [63:0] v);
      logic [63:0] sq;
      sq = (v * v) >> FRAC_W;
      return (sq * v) >> FRAC_W;
    endfunction

    function frame_t settled_frame(phase_t ph);
      frame_t f;
      f.active = 1'b0;
      f.phase = ph;
      if (ph == PH_VISIBLE) begin
        f.alpha = ONE;
        f.offset = '0;
      end else begin
        f.alpha = '0;
        f.offset = distance_reg;
      end
      return f;
    endfunction

    function void note_command(logic [1:0] fn, logic [TIME_W-1:0] now_ms);
      frame_t      f;
      logic [63:0] dur, elapsed, prog, x;
      case (fn)
        FN_FADE_IN: begin
          mode = PH_IN;
          start_stamp = now_ms;
        end
        FN_FADE_OUT: begin
          if (mode != PH_HIDDEN) begin
            mode = PH_OUT;
            start_stamp = now_ms;
          end
        end
        FN_TICK: begin
          if (mode == PH_HIDDEN || mode == PH_VISIBLE) begin
            pending_frames.push_back(settled_frame(mode));
            return;
          end
          dur = 64'(effective_duration());
          elapsed = (now_ms >= start_stamp) ? 64'(now_ms - start_stamp) : 64'd0;
          if (elapsed >= dur) begin
            mode = (mode == PH_IN) ? PH_VISIBLE : PH_HIDDEN;
            pending_frames.push_back(settled_frame(mode));
            return;
          end
          prog = (elapsed << FRAC_W) / dur;
          x = (mode == PH_IN) ? cube_q(64'(ONE) - prog) : cube_q(prog);
          f.alpha = ALPHA_W'(64'(ONE) - x);
          f.offset = REG_W'((64'(distance_reg) * x) >> FRAC_W);
          f.active = 1'b1;
          f.phase = mode;
          pending_frames.push_back(f);
        end
        default: ;
      endcase
    endfunction

    function void check_frame(logic [39:0] data);
      frame_t got, want;
      got.alpha = data[16:0];
      got.offset = data[32:17];
      got.active = data[33];
      got.phase = phase_t'(data[35:34]);
      if (pending_frames.size() == 0) begin
        flag($sformatf("result %h arrived with nothing expected", data));
        return;
      end
      want = pending_frames.pop_front();
      if (got.alpha !== want.alpha || got.offset !== want.offset ||
          got.active !== want.active || got.phase !== want.phase)
        flag($sformatf("alpha %0d/%0d offset %0d/%0d active %0d/%0d phase %0d/%0d (exp/got)",
                       want.alpha, got.alpha, want.offset, got.offset,
                       want.active, got.active, want.phase, got.phase));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // now_time[31:0]
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // alpha[16:0], offset[32:17], active[33], phase[35:34]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bit             stall_en = 1'b0;
  int             ready_hold = 0;
  fade_scoreboard tracker = new();

  fade_slide_animation_easer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    if (!stall_en) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) tracker.check_frame(m_tdata);
  end

  // The valid line is touched once per falling edge: either dropped for a gap or
  // raised for the next transfer.
  task automatic send_item(input logic [1:0] fn, input logic [31:0] now_ms);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= now_ms;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_command(fn, now_ms);
  endtask

  // Waits until every expected result has arrived, then lets the block sit idle for
  // the settle time; start commands give no result and leave the block idle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [REG_W-1:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_register(addr, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[15:0] !== value)
      tracker.flag($sformatf("register at %0d reads %h, wrote %h", addr, readback, value));
  endtask

  task automatic run_random(input int target);
    int          sent, n_ticks, roll, span;
    logic [31:0] t0, clock_ms;
    sent = 0;
    while (sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        // A whole fade: a start, then ticks that mostly move forward (some fall before the start) until it likely ends.
        t0 = $urandom;
        clock_ms = t0;
        span = tracker.effective_duration();
        send_item($urandom_range(0, 1) ? FN_FADE_IN : FN_FADE_OUT, t0);
        n_ticks = $urandom_range(1, 12);
        repeat (n_ticks) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(FN_TICK, t0 - $urandom_range(1, 1000));
          end else begin
            clock_ms += $urandom_range(0, span / 4 + 1);
            send_item(FN_TICK, clock_ms);
          end
        end
        sent += n_ticks + 1;
      end else if (roll < 85) begin
        send_item(FN_TICK, $urandom);
        sent++;
      end else if (roll < 95) begin
        send_item($urandom_range(0, 1) ? FN_RESERVED : FN_FADE_OUT, $urandom);
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_register(ADDR_DURATION, 16'd200);
    write_register(ADDR_DISTANCE, 16'd5120);

    send_item(FN_TICK, 32'd0);
    send_item(FN_FADE_OUT, 32'd10);         // ignored while hidden
    send_item(FN_RESERVED, 32'd20);
    send_item(FN_TICK, 32'hFFFF_FFFF);
    send_item(FN_FADE_IN, 32'd1000);
    send_item(FN_TICK, 32'd1000);
    send_item(FN_TICK, 32'd1001);
    send_item(FN_TICK, 32'd1100);
    send_item(FN_TICK, 32'd999);            // time ran backwards
    send_item(FN_TICK, 32'd1199);
    send_item(FN_RESERVED, 32'd1150);
    send_item(FN_TICK, 32'd1200);           // fade-in completes
    send_item(FN_TICK, 32'd0);
    send_item(FN_FADE_IN, 32'd2000);        // restart from visible
    send_item(FN_TICK, 32'd2050);
    send_item(FN_FADE_OUT, 32'd2100);       // interrupts the fade-in
    send_item(FN_TICK, 32'd2100);
    send_item(FN_TICK, 32'd2150);
    send_item(FN_TICK, 32'd2299);
    send_item(FN_FADE_IN, 32'd2200);
    send_item(FN_TICK, 32'd2300);
    send_item(FN_FADE_OUT, 32'hFFFF_FF00);
    send_item(FN_TICK, 32'hFFFF_FFFF);      // fade-out completes
    send_item(FN_FADE_IN, 32'hFFFF_FFFF);
    send_item(FN_TICK, 32'd0);

    for (int setting = 0; setting < 6; setting++) begin
      drain();
      case (setting)
        0: begin
          write_register(ADDR_DURATION, 16'd1);
          write_register(ADDR_DISTANCE, 16'hFFFF);
        end
        1: begin
          write_register(ADDR_DURATION, 16'hFFFF);
          write_register(ADDR_DISTANCE, 16'd0);
        end
        2: begin
          // A zero duration behaves as the default length.
          write_register(ADDR_DURATION, 16'd0);
          write_register(ADDR_DISTANCE, 16'($urandom_range(0, 65535)));
        end
        4: begin
          write_register(ADDR_DURATION, 16'($urandom_range(2, 50)));
          write_register(ADDR_DISTANCE, 16'hFFFF);
        end
        default: begin
          write_register(ADDR_DURATION, 16'($urandom_range(1, 65535)));
          write_register(ADDR_DISTANCE, 16'($urandom_range(0, 65535)));
        end
      endcase
      stall_en = (setting != 3);
      run_random(RANDOM_PER_SETTING);
    end

    drain();
    if (tracker.mismatches == 0) begin
      $display("PASS fade_slide_animation_easer_top");
    end else begin
      $display("FAIL fade_slide_animation_easer_top");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("FAIL fade_slide_animation_easer_top");
    $finish;
  end

endmodule
